FILE: hdl/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types, widths and codes of the sweep-and-prune pair finder.
// ----------------------------------------------------------------------------
package spp_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_PROXIES_DEF   = 16;
  localparam int PAIR_CAPACITY_DEF = 63;
  localparam int ID_WIDTH_DEF      = 16;

  // Fixed field widths
  localparam int ID_FIELD_W = 16;
  localparam int COORD_W    = 34;

  // Shape kind codes; the unused code is handled as a box
  localparam logic [1:0] SHAPE_SPHERE  = 2'd0;
  localparam logic [1:0] SHAPE_BOX     = 2'd1;
  localparam logic [1:0] SHAPE_CAPSULE = 2'd2;

  // Saturation limits of a bound (Q18.16)
  localparam logic signed [COORD_W-1:0] BOUND_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] BOUND_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // One proxy as it arrives
  typedef struct packed {
    logic [ID_FIELD_W-1:0] collider_id;
    logic [1:0]            shape_kind;
    logic signed [31:0]    center_x;
    logic signed [31:0]    end_b_x;
    logic [30:0]           radius;
    logic signed [15:0]    axis0_x;
    logic signed [15:0]    axis1_x;
    logic signed [15:0]    axis2_x;
    logic [30:0]           half_x;
    logic [30:0]           half_y;
    logic [30:0]           half_z;
    logic                  last_proxy;
  } in_item_t;

  // Bounds of one proxy handed to the engine
  typedef struct packed {
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
    logic                      last;
  } bounds_t;

  // One result transaction
  typedef struct packed {
    logic [ID_FIELD_W-1:0] first_id;
    logic [ID_FIELD_W-1:0] second_id;
    logic                  pair_valid;
    logic                  overflow;
    logic                  last_pair;
  } out_item_t;

endpackage

FILE: hdl/spp_if.sv
// ----------------------------------------------------------------------------
// spp_if
// Valid/ready channels of the pair finder: proxy input and pair output.
// ----------------------------------------------------------------------------
interface spp_in_if;
  logic                            valid;
  logic                            ready;
  logic [spp_pkg::ID_FIELD_W-1:0]  collider_id;
  logic [1:0]                      shape_kind;
  logic signed [31:0]              center_x;
  logic signed [31:0]              end_b_x;
  logic [30:0]                     radius;
  logic signed [15:0]              axis0_x;
  logic signed [15:0]              axis1_x;
  logic signed [15:0]              axis2_x;
  logic [30:0]                     half_x;
  logic [30:0]                     half_y;
  logic [30:0]                     half_z;
  logic                            last_proxy;

  modport source (
    output valid, collider_id, shape_kind, center_x, end_b_x, radius,
           axis0_x, axis1_x, axis2_x, half_x, half_y, half_z, last_proxy,
    input  ready
  );
  modport sink (
    input  valid, collider_id, shape_kind, center_x, end_b_x, radius,
           axis0_x, axis1_x, axis2_x, half_x, half_y, half_z, last_proxy,
    output ready
  );
endinterface

interface spp_out_if;
  logic                            valid;
  logic                            ready;
  logic [spp_pkg::ID_FIELD_W-1:0]  first_id;
  logic [spp_pkg::ID_FIELD_W-1:0]  second_id;
  logic                            pair_valid;
  logic                            overflow;
  logic                            last_pair;

  modport source (
    output valid, first_id, second_id, pair_valid, overflow, last_pair,
    input  ready
  );
  modport sink (
    input  valid, first_id, second_id, pair_valid, overflow, last_pair,
    output ready
  );
endinterface

FILE: hdl/spp_ram.sv
// ----------------------------------------------------------------------------
// spp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/spp_bounds.sv
// ----------------------------------------------------------------------------
// spp_bounds
// Two-stage x-bound unit: registered box products, then bound select and
// saturation to 34 bits.
// ----------------------------------------------------------------------------
module spp_bounds (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  spp_pkg::in_item_t              item,
  output logic                           busy,
  output logic                           out_valid,
  output spp_pkg::bounds_t               bnd,
  output logic [spp_pkg::ID_FIELD_W-1:0] out_id
);

  // stage 1 registers
  logic                           v1;
  logic [46:0]                    p0, p1, p2;
  logic signed [31:0]             c1, b1;
  logic [30:0]                    r1;
  logic [1:0]                     kind1;
  logic                           last1;
  logic [spp_pkg::ID_FIELD_W-1:0] id1;

  // stage 2 registers
  logic v2;

  // stage 2 logic
  logic [48:0]        sum;
  logic [34:0]        ext;
  logic signed [36:0] cw, bw, rw, ew, lo_w, hi_w, mn_w, mx_w;

  function automatic logic [15:0] mag16(logic [15:0] a);
    return a[15] ? (~a + 16'd1) : a;
  endfunction

  function automatic logic signed [33:0] sat34(logic signed [36:0] v);
    if (v[36:33] == {4{v[36]}}) begin
      return v[33:0];
    end else if (v[36]) begin
      return spp_pkg::BOUND_MIN;
    end else begin
      return spp_pkg::BOUND_MAX;
    end
  endfunction

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // stage 1: one product per box axis
  always_ff @(posedge clk) begin
    if (in_valid) begin
      p0    <= 47'(mag16(item.axis0_x)) * 47'(item.half_x);
      p1    <= 47'(mag16(item.axis1_x)) * 47'(item.half_y);
      p2    <= 47'(mag16(item.axis2_x)) * 47'(item.half_z);
      c1    <= item.center_x;
      b1    <= item.end_b_x;
      r1    <= item.radius;
      kind1 <= item.shape_kind;
      last1 <= item.last_proxy;
      id1   <= item.collider_id;
    end
  end

  // stage 2: extent sum and per-shape bounds
  always_comb begin
    sum  = 49'(p0) + 49'(p1) + 49'(p2);
    ext  = sum[48:14];
    cw   = {{5{c1[31]}}, c1};
    bw   = {{5{b1[31]}}, b1};
    rw   = {6'b0, r1};
    ew   = {2'b0, ext};
    mn_w = (cw < bw) ? cw : bw;
    mx_w = (cw < bw) ? bw : cw;
    case (kind1)
      spp_pkg::SHAPE_SPHERE: begin
        lo_w = cw - rw;
        hi_w = cw + rw;
      end
      spp_pkg::SHAPE_CAPSULE: begin
        lo_w = mn_w - rw;
        hi_w = mx_w + rw;
      end
      default: begin
        lo_w = cw - ew;
        hi_w = cw + ew;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      bnd.lo   <= sat34(lo_w);
      bnd.hi   <= sat34(hi_w);
      bnd.last <= last1;
      out_id   <= id1;
    end
  end

  assign busy      = v1 | v2;
  assign out_valid = v2;

endmodule

FILE: hdl/spp_engine.sv
// ----------------------------------------------------------------------------
// spp_engine
// Memory sequencer: stores proxy bounds, ranks endpoints into a sorted store,
// sweeps them over an active list into the pair store, and emits the pairs in
// ascending order by repeated minimum search.
// ----------------------------------------------------------------------------
module spp_engine #(
  parameter int MAX_PROXIES   = spp_pkg::MAX_PROXIES_DEF,
  parameter int PAIR_CAPACITY = spp_pkg::PAIR_CAPACITY_DEF,
  parameter int ID_WIDTH      = spp_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                prx_valid,
  input  spp_pkg::bounds_t    prx,
  input  logic [ID_WIDTH-1:0] prx_id,
  output logic                idle,
  output logic                res_valid,
  output spp_pkg::out_item_t  res,
  input  logic                res_ready
);

  localparam int CW  = spp_pkg::COORD_W;
  localparam int PCW = $clog2(MAX_PROXIES + 1);
  localparam int PIW = $clog2(MAX_PROXIES);
  localparam int EIW = $clog2(2 * MAX_PROXIES);
  localparam int ECW = EIW + 1;
  localparam int PKW = $clog2(PAIR_CAPACITY + 1);
  localparam int PAW = (PAIR_CAPACITY > 1) ? $clog2(PAIR_CAPACITY) : 1;
  localparam int PXW = 2 * CW + ID_WIDTH;
  localparam int EPW = CW + 1 + ID_WIDTH;
  localparam int PRW = 2 * ID_WIDTH;

  // sequencer states
  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_ACK      = 5'd1;
  localparam logic [4:0] ST_RK_FETCH = 5'd2;
  localparam logic [4:0] ST_RK_KEY   = 5'd3;
  localparam logic [4:0] ST_RK_RD    = 5'd4;
  localparam logic [4:0] ST_RK_CMP   = 5'd5;
  localparam logic [4:0] ST_SW_RD    = 5'd6;
  localparam logic [4:0] ST_SW_GET   = 5'd7;
  localparam logic [4:0] ST_AC_RD    = 5'd8;
  localparam logic [4:0] ST_AC_GET   = 5'd9;
  localparam logic [4:0] ST_PR_RD    = 5'd10;
  localparam logic [4:0] ST_PR_GET   = 5'd11;
  localparam logic [4:0] ST_PR_ADD   = 5'd12;
  localparam logic [4:0] ST_SW_PUSH  = 5'd13;
  localparam logic [4:0] ST_RM_RD    = 5'd14;
  localparam logic [4:0] ST_RM_GET   = 5'd15;
  localparam logic [4:0] ST_RM_LRD   = 5'd16;
  localparam logic [4:0] ST_RM_LGET  = 5'd17;
  localparam logic [4:0] ST_OR_RD    = 5'd18;
  localparam logic [4:0] ST_OR_GET   = 5'd19;
  localparam logic [4:0] ST_OUT      = 5'd20;

  logic [4:0] state;

  // control registers
  logic [PCW-1:0] cnt, ac, j;
  logic           povf, wovf;
  logic [PKW-1:0] pc, k, rnd;
  logic [ECW-1:0] e_idx, i_idx;
  logic [EIW-1:0] rank;

  // working registers
  logic signed [CW-1:0] key_c;
  logic                 key_m;
  logic [ID_WIDTH-1:0]  key_id;
  logic [PRW-1:0]       cand, best, prev;
  logic                 bvalid, have_prev;

  // memory ports
  logic           prx_we;
  logic [PIW-1:0] prx_waddr, prx_raddr;
  logic [PXW-1:0] prx_rdata;
  logic           ep_we;
  logic [EIW-1:0] ep_raddr;
  logic [EPW-1:0] ep_rdata;
  logic           act_we;
  logic [PIW-1:0] act_waddr, act_raddr;
  logic [ID_WIDTH-1:0] act_wdata, act_rdata;
  logic           pr_we;
  logic [PAW-1:0] pr_raddr;
  logic [PRW-1:0] pr_rdata;

  // ranking compare
  logic signed [CW-1:0] px_min, px_max;
  logic [ID_WIDTH-1:0]  px_id;
  logic [ECW-1:0]       idx0, idx1;
  logic                 c0, c1;
  logic [EIW-1:0]       rank_next;

  logic [ECW-1:0] n2;
  logic           last_j, last_act, last_ep, last_pr;
  logic [PRW-1:0] cand_next;

  function automatic logic ep_before(
    logic signed [CW-1:0] ca, logic ma, logic [ID_WIDTH-1:0] ia,
    logic signed [CW-1:0] cb, logic mb, logic [ID_WIDTH-1:0] ib
  );
    if (ca != cb) begin
      return ca < cb;
    end
    if (ma != mb) begin
      return ma;
    end
    return ia < ib;
  endfunction

  function automatic logic [spp_pkg::ID_FIELD_W-1:0] to_field(logic [ID_WIDTH-1:0] v);
    logic [ID_WIDTH+spp_pkg::ID_FIELD_W-1:0] w;
    w = {{spp_pkg::ID_FIELD_W{1'b0}}, v};
    return w[spp_pkg::ID_FIELD_W-1:0];
  endfunction

  // memories
  spp_ram #(.WIDTH(PXW), .DEPTH(MAX_PROXIES)) u_prx_ram (
    .clk(clk), .we(prx_we), .waddr(prx_waddr), .wdata({prx_id, prx.hi, prx.lo}),
    .raddr(prx_raddr), .rdata(prx_rdata)
  );
  spp_ram #(.WIDTH(EPW), .DEPTH(2 * MAX_PROXIES)) u_ep_ram (
    .clk(clk), .we(ep_we), .waddr(rank_next), .wdata({key_c, key_m, key_id}),
    .raddr(ep_raddr), .rdata(ep_rdata)
  );
  spp_ram #(.WIDTH(ID_WIDTH), .DEPTH(MAX_PROXIES)) u_act_ram (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(act_raddr), .rdata(act_rdata)
  );
  spp_ram #(.WIDTH(PRW), .DEPTH(PAIR_CAPACITY)) u_pair_ram (
    .clk(clk), .we(pr_we), .waddr(pc[PAW-1:0]), .wdata(cand),
    .raddr(pr_raddr), .rdata(pr_rdata)
  );

  // rank of the held endpoint against both endpoints of proxy j
  always_comb begin
    px_min    = prx_rdata[CW-1:0];
    px_max    = prx_rdata[2*CW-1:CW];
    px_id     = prx_rdata[PXW-1:2*CW];
    idx0      = ECW'({j, 1'b0});
    idx1      = idx0 + 1'b1;
    c0        = ep_before(px_min, 1'b1, px_id, key_c, key_m, key_id) ||
                (px_min == key_c && key_m && px_id == key_id && idx0 < e_idx);
    c1        = ep_before(px_max, 1'b0, px_id, key_c, key_m, key_id) ||
                (px_max == key_c && !key_m && px_id == key_id && idx1 < e_idx);
    rank_next = rank + EIW'(c0) + EIW'(c1);
  end

  // loop bounds
  always_comb begin
    n2        = ECW'({cnt, 1'b0});
    last_j    = (PCW'(j + 1'b1) == cnt);
    last_act  = (PCW'(j + 1'b1) == ac);
    last_ep   = (ECW'(i_idx + 1'b1) == n2);
    last_pr   = (PKW'(k + 1'b1) == pc);
    cand_next = (key_id < act_rdata) ? {key_id, act_rdata} : {act_rdata, key_id};
  end

  // memory controls
  always_comb begin
    prx_we    = 1'b0;
    prx_waddr = cnt[PIW-1:0];
    prx_raddr = j[PIW-1:0];
    ep_we     = 1'b0;
    ep_raddr  = i_idx[EIW-1:0];
    act_we    = 1'b0;
    act_waddr = ac[PIW-1:0];
    act_wdata = key_id;
    act_raddr = j[PIW-1:0];
    pr_we     = 1'b0;
    pr_raddr  = k[PAW-1:0];
    unique case (state)
      ST_IDLE:     prx_we = prx_valid && (cnt < PCW'(MAX_PROXIES));
      ST_RK_FETCH: prx_raddr = e_idx[PIW:1];
      ST_RK_CMP:   ep_we = last_j;
      ST_PR_ADD:   pr_we = (pc < PKW'(PAIR_CAPACITY));
      ST_SW_PUSH:  act_we = (ac < PCW'(MAX_PROXIES));
      ST_RM_LRD:   act_raddr = PIW'(ac - 1'b1);
      ST_RM_LGET: begin
        act_we    = 1'b1;
        act_waddr = j[PIW-1:0];
        act_wdata = act_rdata;
      end
      default: ;
    endcase
  end

  // result transaction
  always_comb begin
    res_valid     = (state == ST_ACK) || (state == ST_OUT);
    res.first_id  = '0;
    res.second_id = '0;
    res.pair_valid = 1'b0;
    res.overflow  = povf;
    res.last_pair = 1'b0;
    if (state == ST_OUT) begin
      res.overflow  = povf | wovf;
      if (pc == '0) begin
        res.last_pair = 1'b1;
      end else begin
        res.first_id   = to_field(best[PRW-1:ID_WIDTH]);
        res.second_id  = to_field(best[ID_WIDTH-1:0]);
        res.pair_valid = 1'b1;
        res.last_pair  = (PKW'(rnd + 1'b1) == pc);
      end
    end
  end

  assign idle = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      povf  <= 1'b0;
      wovf  <= 1'b0;
      ac    <= '0;
      pc    <= '0;
    end else begin
      unique case (state)
        // load one proxy
        ST_IDLE: begin
          if (prx_valid) begin
            if (cnt < PCW'(MAX_PROXIES)) begin
              cnt <= cnt + 1'b1;
            end else begin
              povf <= 1'b1;
            end
            e_idx <= '0;
            state <= prx.last ? ST_RK_FETCH : ST_ACK;
          end
        end
        ST_ACK: begin
          if (res_ready) state <= ST_IDLE;
        end
        // rank each endpoint against all endpoints
        ST_RK_FETCH: state <= ST_RK_KEY;
        ST_RK_KEY: begin
          key_m  <= !e_idx[0];
          key_c  <= e_idx[0] ? prx_rdata[2*CW-1:CW] : prx_rdata[CW-1:0];
          key_id <= prx_rdata[PXW-1:2*CW];
          rank   <= '0;
          j      <= '0;
          state  <= ST_RK_RD;
        end
        ST_RK_RD: state <= ST_RK_CMP;
        ST_RK_CMP: begin
          rank <= rank_next;
          j    <= j + 1'b1;
          if (!last_j) begin
            state <= ST_RK_RD;
          end else if (ECW'(e_idx + 1'b1) == n2) begin
            i_idx <= '0;
            ac    <= '0;
            pc    <= '0;
            state <= ST_SW_RD;
          end else begin
            e_idx <= e_idx + 1'b1;
            state <= ST_RK_FETCH;
          end
        end
        // sweep sorted endpoints
        ST_SW_RD: state <= ST_SW_GET;
        ST_SW_GET: begin
          key_m  <= ep_rdata[ID_WIDTH];
          key_id <= ep_rdata[ID_WIDTH-1:0];
          j      <= '0;
          if (ep_rdata[ID_WIDTH]) begin
            state <= (ac == '0) ? ST_SW_PUSH : ST_AC_RD;
          end else if (ac != '0) begin
            state <= ST_RM_RD;
          end else if (last_ep) begin
            state <= ST_OR_RD;
          end else begin
            i_idx <= i_idx + 1'b1;
            state <= ST_SW_RD;
          end
        end
        ST_AC_RD: state <= ST_AC_GET;
        ST_AC_GET: begin
          cand  <= cand_next;
          k     <= '0;
          state <= (pc == '0) ? ST_PR_ADD : ST_PR_RD;
        end
        // duplicate search in the pair store
        ST_PR_RD: state <= ST_PR_GET;
        ST_PR_GET: begin
          if (pr_rdata == cand) begin
            j     <= j + 1'b1;
            state <= last_act ? ST_SW_PUSH : ST_AC_RD;
          end else if (last_pr) begin
            state <= ST_PR_ADD;
          end else begin
            k     <= k + 1'b1;
            state <= ST_PR_RD;
          end
        end
        ST_PR_ADD: begin
          if (pc < PKW'(PAIR_CAPACITY)) begin
            pc <= pc + 1'b1;
          end else begin
            wovf <= 1'b1;
          end
          j     <= j + 1'b1;
          state <= last_act ? ST_SW_PUSH : ST_AC_RD;
        end
        ST_SW_PUSH: begin
          if (ac < PCW'(MAX_PROXIES)) ac <= ac + 1'b1;
          i_idx <= i_idx + 1'b1;
          k     <= '0;
          bvalid    <= 1'b0;
          have_prev <= 1'b0;
          rnd   <= '0;
          state <= last_ep ? ((pc == '0) ? ST_OUT : ST_OR_RD) : ST_SW_RD;
        end
        // removal: first match, last entry moves into its place
        ST_RM_RD: state <= ST_RM_GET;
        ST_RM_GET: begin
          if (act_rdata == key_id && !last_act) begin
            state <= ST_RM_LRD;
          end else if (act_rdata != key_id && !last_act) begin
            j     <= j + 1'b1;
            state <= ST_RM_RD;
          end else begin
            if (act_rdata == key_id) ac <= ac - 1'b1;
            i_idx <= i_idx + 1'b1;
            k     <= '0;
            bvalid    <= 1'b0;
            have_prev <= 1'b0;
            rnd   <= '0;
            state <= last_ep ? ((pc == '0) ? ST_OUT : ST_OR_RD) : ST_SW_RD;
          end
        end
        ST_RM_LRD: state <= ST_RM_LGET;
        ST_RM_LGET: begin
          ac    <= ac - 1'b1;
          i_idx <= i_idx + 1'b1;
          k     <= '0;
          bvalid    <= 1'b0;
          have_prev <= 1'b0;
          rnd   <= '0;
          state <= last_ep ? ((pc == '0) ? ST_OUT : ST_OR_RD) : ST_SW_RD;
        end
        // next pair in order: smallest above the previous one
        ST_OR_RD: begin
          if (pc == '0) begin
            state <= ST_OUT;
          end else begin
            state <= ST_OR_GET;
          end
        end
        ST_OR_GET: begin
          if ((!have_prev || pr_rdata > prev) && (!bvalid || pr_rdata < best)) begin
            best   <= pr_rdata;
            bvalid <= 1'b1;
          end
          k     <= k + 1'b1;
          state <= last_pr ? ST_OUT : ST_OR_RD;
        end
        ST_OUT: begin
          if (res_ready) begin
            if (pc == '0 || PKW'(rnd + 1'b1) == pc) begin
              cnt   <= '0;
              povf  <= 1'b0;
              wovf  <= 1'b0;
              ac    <= '0;
              pc    <= '0;
              state <= ST_IDLE;
            end else begin
              prev      <= best;
              have_prev <= 1'b1;
              rnd       <= rnd + 1'b1;
              k         <= '0;
              bvalid    <= 1'b0;
              state     <= ST_OR_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/sweep_prune_pair_finder.sv
// ----------------------------------------------------------------------------
// sweep_prune_pair_finder
// Single-axis sweep-and-prune broadphase: loads shape proxies and reports
// overlapping id pairs along x.
// ----------------------------------------------------------------------------
// Usage:
//   proxy: one shape proxy per transaction. Every proxy without last_proxy
//   is answered by one acknowledge result (pair_valid = 0, last_pair = 0).
//   The ack reaches pair through the two bound stages, the engine's load
//   state (proxy memory write) and the output register, and the next proxy
//   can be accepted once the ack has moved into the output register.
//   The proxy with last_proxy closes the set.
//   pair: after the closing proxy the engine ranks the 2n endpoints against
//   the proxy memory, sweeps them over the active list with a pair-store
//   duplicate search per candidate (data dependent), then emits the pairs
//   in ascending order. With no pair one result with last_pair = 1 is sent.
//   A new proxy is accepted while a result waits in the output register;
//   a stalled receiver holds that register and the engine waits behind it.
//   Reset clears counts and flags; the memories hold no reset value and
//   need no clearing pass.
// ----------------------------------------------------------------------------
module sweep_prune_pair_finder #(
  parameter int MAX_PROXIES   = spp_pkg::MAX_PROXIES_DEF,
  parameter int PAIR_CAPACITY = spp_pkg::PAIR_CAPACITY_DEF,
  parameter int ID_WIDTH      = spp_pkg::ID_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  spp_in_if.sink       proxy,
  spp_out_if.source    pair
);

  spp_pkg::in_item_t              item;
  spp_pkg::bounds_t               bnd;
  logic [spp_pkg::ID_FIELD_W-1:0] bnd_id;
  logic [ID_WIDTH-1:0]            prx_id;
  logic                           bnd_busy, bnd_valid, eng_idle;
  logic                           res_valid, res_ready;
  spp_pkg::out_item_t             res;
  logic                           accept;
  logic [ID_WIDTH+spp_pkg::ID_FIELD_W-1:0] id_ext;

  // input transaction
  assign proxy.ready = eng_idle && !bnd_busy;
  assign accept      = proxy.valid && proxy.ready;

  always_comb begin
    item.collider_id = proxy.collider_id;
    item.shape_kind  = proxy.shape_kind;
    item.center_x    = proxy.center_x;
    item.end_b_x     = proxy.end_b_x;
    item.radius      = proxy.radius;
    item.axis0_x     = proxy.axis0_x;
    item.axis1_x     = proxy.axis1_x;
    item.axis2_x     = proxy.axis2_x;
    item.half_x      = proxy.half_x;
    item.half_y      = proxy.half_y;
    item.half_z      = proxy.half_z;
    item.last_proxy  = proxy.last_proxy;
  end

  spp_bounds u_bounds (
    .clk(clk), .rst(rst), .in_valid(accept), .item(item), .busy(bnd_busy),
    .out_valid(bnd_valid), .bnd(bnd), .out_id(bnd_id)
  );

  // id masked to the configured width
  assign id_ext = {{ID_WIDTH{1'b0}}, bnd_id};
  assign prx_id = id_ext[ID_WIDTH-1:0];

  spp_engine #(
    .MAX_PROXIES(MAX_PROXIES), .PAIR_CAPACITY(PAIR_CAPACITY), .ID_WIDTH(ID_WIDTH)
  ) u_engine (
    .clk(clk), .rst(rst), .prx_valid(bnd_valid), .prx(bnd), .prx_id(prx_id),
    .idle(eng_idle), .res_valid(res_valid), .res(res), .res_ready(res_ready)
  );

  // output register
  assign res_ready = !pair.valid || pair.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair.valid <= 1'b0;
    end else if (res_ready) begin
      pair.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      pair.first_id   <= res.first_id;
      pair.second_id  <= res.second_id;
      pair.pair_valid <= res.pair_valid;
      pair.overflow   <= res.overflow;
      pair.last_pair  <= res.last_pair;
    end
  end

endmodule

FILE: hdl/spp_checker.sv
// ----------------------------------------------------------------------------
// spp_checker
// Port-level checks of the pair finder, bound to the top level.
// ----------------------------------------------------------------------------
module spp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [spp_pkg::ID_FIELD_W-1:0] first_id,
  input logic [spp_pkg::ID_FIELD_W-1:0] second_id,
  input logic                           pair_valid,
  input logic                           overflow,
  input logic                           last_pair
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_id) && $stable(second_id)
      && $stable(pair_valid) && $stable(overflow) && $stable(last_pair))
    else $error("result changed under stall");

  // acks and empty sets carry zero ids
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pair_valid |-> first_id == '0 && second_id == '0)
    else $error("nonzero ids without pair");

  // pairs are ordered
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && pair_valid |-> first_id <= second_id)
    else $error("pair ids out of order");

  // one proxy in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // output empty after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sweep_prune_pair_finder spp_checker u_spp_checker (
  .clk(clk), .rst(rst), .in_valid(proxy.valid), .in_ready(proxy.ready),
  .out_valid(pair.valid), .out_ready(pair.ready), .first_id(pair.first_id),
  .second_id(pair.second_id), .pair_valid(pair.pair_valid),
  .overflow(pair.overflow), .last_pair(pair.last_pair)
);
